>>> sv/bitmap_allocator_top_assert.svh
// assertion macros for the bitmap allocator top level
`ifndef BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BMA_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bitmap allocator check failed");

// next-cycle implication
`define BMA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bitmap allocator check failed");

`endif

>>> sv/bma_pkg.sv
// shared constants, types and helper functions for the bitmap allocator
package bma_pkg;

  localparam int WORD_COUNT = 64;
  localparam int WORD_BITS  = 64;

  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_FILL   = 3'd2;
  localparam logic [2:0] CMD_RUN    = 3'd3;
  localparam logic [2:0] CMD_SINGLE = 3'd4;

  localparam logic [12:0] SIZE_MAX = 13'd4096;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] position_in;
    logic [12:0] length;
    logic        bit_value;
  } in_item_t;

  typedef struct packed {
    logic        read_bit;
    logic        found;
    logic [11:0] position_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD,
    ST_MOD,
    ST_SCAN1,
    ST_SCAN2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic ld;
    logic rd;
    logic wr;
    logic grab;
    logic scan;
    logic init2;
    logic zlen;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic       live;
    logic       last_word;
    logic       ptr_nz;
    logic       len_zero;
    logic       hit;
    logic       scan_end;
  } ctrl_stat_t;

  // top n bits set, msb first
  function automatic logic [63:0] lead_ones(input logic [6:0] n);
    logic [63:0] r;
    if (n >= 7'd64) begin
      r = {64{1'b1}};
    end else begin
      r = ~({64{1'b1}} >> n[5:0]);
    end
    return r;
  endfunction

  // msb-first position of the highest set bit
  function automatic logic [5:0] first_one(input logic [63:0] x);
    logic [5:0] j;
    j = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        j = ~6'(i);
      end
    end
    return j;
  endfunction

endpackage

>>> sv/bitmap_allocator_top.sv
// bitmap allocator top level: a 4096-bit map with next-fit search
// read bit and write bit: decode, read, modify, done states; unknown command: decode, done
// range fill: a read-modify-write per word touched, through the single map port
// searches: one word per cycle from the pointer, in up to two passes
// one command at a time, next start taken the cycle after done; results cannot be stalled
// reset: map reads all zero at once via per-word flags, pointer 0, bits_in_use 4096
module bitmap_allocator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bma_pkg::in_item_t  item,
  output logic               done,
  output bma_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [12:0]        cfg_data
);

`include "bitmap_allocator_top_assert.svh"

  bma_pkg::ctrl_cmd_t  ctl;
  bma_pkg::ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  bma_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  bma_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .result    (result)
  );

  `BMA_ASSERT_NEXT(a_done_then_idle, done, !busy)
  `BMA_ASSERT_NEXT(a_start_then_busy, start && !busy, busy && !done)
  `BMA_ASSERT_NOW(a_read_not_found, done && result.read_bit, !result.found)

endmodule

>>> sv/bma_ctrl.sv
// controller state machine for the bitmap allocator
module bma_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bma_pkg::ctrl_stat_t stat,
  output bma_pkg::ctrl_cmd_t  ctl,
  output logic                busy,
  output logic                done
);

  bma_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      bma_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.ld = 1'b1;
          state_next = bma_pkg::ST_DECODE;
        end
      end
      bma_pkg::ST_DECODE: begin
        case (stat.command)
          bma_pkg::CMD_READ, bma_pkg::CMD_WRITE, bma_pkg::CMD_FILL: begin
            state_next = stat.live ? bma_pkg::ST_RD : bma_pkg::ST_DONE;
          end
          bma_pkg::CMD_RUN: begin
            if (stat.len_zero) begin
              ctl.zlen = 1'b1;
              state_next = bma_pkg::ST_DONE;
            end else begin
              state_next = bma_pkg::ST_SCAN1;
            end
          end
          bma_pkg::CMD_SINGLE: state_next = bma_pkg::ST_SCAN1;
          default: state_next = bma_pkg::ST_DONE;
        endcase
      end
      bma_pkg::ST_RD: begin
        ctl.rd = 1'b1;
        state_next = bma_pkg::ST_MOD;
      end
      bma_pkg::ST_MOD: begin
        if (stat.command == bma_pkg::CMD_READ) begin
          ctl.grab = 1'b1;
          state_next = bma_pkg::ST_DONE;
        end else begin
          ctl.wr = 1'b1;
          state_next = stat.last_word ? bma_pkg::ST_DONE : bma_pkg::ST_RD;
        end
      end
      bma_pkg::ST_SCAN1: begin
        ctl.scan = 1'b1;
        if (stat.hit) begin
          state_next = bma_pkg::ST_DONE;
        end else if (stat.scan_end) begin
          if (stat.ptr_nz) begin
            ctl.scan = 1'b0;
            ctl.init2 = 1'b1;
            state_next = bma_pkg::ST_SCAN2;
          end else begin
            state_next = bma_pkg::ST_DONE;
          end
        end
      end
      bma_pkg::ST_SCAN2: begin
        ctl.scan = 1'b1;
        if (stat.hit || stat.scan_end) begin
          state_next = bma_pkg::ST_DONE;
        end
      end
      bma_pkg::ST_DONE: begin
        done = 1'b1;
        state_next = bma_pkg::ST_IDLE;
      end
      default: state_next = bma_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> sv/bma_datapath.sv
// map memory, search pointer, scan logic and result registers
module bma_datapath (
  input  logic                clk,
  input  logic                rst,
  input  bma_pkg::in_item_t   item,
  input  logic                cfg_valid,
  input  logic [12:0]         cfg_data,
  input  bma_pkg::ctrl_cmd_t  ctl,
  output bma_pkg::ctrl_stat_t stat,
  output bma_pkg::out_item_t  result
);

  logic [63:0] mem [bma_pkg::WORD_COUNT];
  logic [63:0] word_ok;
  logic [63:0] rdata;
  logic        rvalid;

  logic [12:0] bits_in_use;
  logic [12:0] size;
  logic [12:0] size_m1;
  logic [6:0]  last_w;

  bma_pkg::in_item_t  op;
  bma_pkg::out_item_t res;
  logic [12:0] fend;
  logic [6:0]  addr;
  logic [6:0]  end_w;
  logic [12:0] limit;
  logic        live;
  logic        pipe_v;
  logic [5:0]  eval_w;
  logic [6:0]  cnt;
  logic [6:0]  ptr;

  logic        rmw_in;
  logic [12:0] eff_len, fend_n, fend_m1;
  logic [13:0] sum;
  logic [12:0] ptr64;
  logic        ptr_le;
  logic        is_run;
  logic [6:0]  end2;
  logic [12:0] limit2;

  logic        re, we, issue;
  logic [63:0] d, pat, wdata, mask;
  logic [6:0]  lo, hi;
  logic [12:0] hi_d;

  logic [12:0] w13;
  logic        full_match, part_ok, run_hit, hit1, hit;
  logic [5:0]  r;
  logic [6:0]  k, cnt_inc, run_ptr, run_s;
  logic [12:0] diff;
  logic [63:0] mt;
  logic [5:0]  j;

  assign size    = (bits_in_use > bma_pkg::SIZE_MAX) ? bma_pkg::SIZE_MAX : bits_in_use;
  assign size_m1 = size - 13'd1;
  assign last_w  = size_m1[12:6];

  // item load
  assign rmw_in  = (item.command == bma_pkg::CMD_READ) || (item.command == bma_pkg::CMD_WRITE)
                   || (item.command == bma_pkg::CMD_FILL);
  assign eff_len = (item.command == bma_pkg::CMD_FILL) ? item.length : 13'd1;
  assign sum     = {2'b0, item.position_in} + {1'b0, eff_len};
  assign fend_n  = (sum > {1'b0, size}) ? size : sum[12:0];
  assign fend_m1 = fend_n - 13'd1;

  // second pass bounds
  assign ptr64  = {ptr, 6'b0};
  assign ptr_le = ptr64 <= size;
  assign is_run = op.command == bma_pkg::CMD_RUN;
  assign end2   = is_run ? ((ptr < last_w) ? ptr : last_w)
                         : (ptr_le ? (ptr - 7'd1) : last_w);
  assign limit2 = (is_run || !ptr_le) ? size : ptr64;

  assign d   = rvalid ? rdata : '0;
  assign pat = {64{op.bit_value}};

  // read-modify-write mask
  assign hi_d  = fend - {1'b0, addr[5:0], 6'b0};
  assign lo    = (addr[5:0] == op.position_in[11:6]) ? {1'b0, op.position_in[5:0]} : 7'd0;
  assign hi    = (addr == end_w) ? hi_d[6:0] : 7'd64;
  assign mask  = bma_pkg::lead_ones(hi) & ~bma_pkg::lead_ones(lo);
  assign wdata = (d & ~mask) | (pat & mask);

  // run evaluation
  assign w13        = {1'b0, eval_w, 6'b0};
  assign r          = op.length[5:0];
  assign k          = op.length[12:6];
  assign full_match = ((w13 + 13'd64) <= size) && (d == pat);
  assign part_ok    = (((d ^ pat) & bma_pkg::lead_ones({1'b0, r})) == '0)
                      && ((w13 + {7'd0, r}) <= size);
  assign cnt_inc    = cnt + 7'd1;
  assign run_hit    = (r != 6'd0) ? ((cnt >= k) && part_ok) : (full_match && (cnt_inc >= k));
  assign run_ptr    = (r != 6'd0) ? {1'b0, eval_w} : ({1'b0, eval_w} + 7'd1);
  assign run_s      = run_ptr - k;

  // single bit evaluation
  assign diff = limit - w13;
  assign mt   = (op.bit_value ? d : ~d) & bma_pkg::lead_ones((diff >= 13'd64) ? 7'd64 : diff[6:0]);
  assign hit1 = mt != '0;
  assign j    = bma_pkg::first_one(mt);

  assign hit   = pipe_v && (is_run ? run_hit : hit1);
  assign issue = live && (addr <= end_w);
  assign re    = ctl.rd || (ctl.scan && issue);
  assign we    = ctl.wr;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata  <= mem[addr[5:0]];
      rvalid <= word_ok[addr[5:0]];
    end
    if (we) begin
      mem[addr[5:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_ok     <= '0;
      bits_in_use <= bma_pkg::SIZE_MAX;
      ptr         <= '0;
      pipe_v      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bits_in_use <= cfg_data;
      end
      if (we) begin
        word_ok[addr[5:0]] <= 1'b1;
      end
      if (ctl.ld) begin
        pipe_v <= 1'b0;
      end else if (ctl.init2) begin
        pipe_v <= 1'b0;
      end else if (ctl.scan) begin
        pipe_v <= issue;
      end
      if (ctl.scan && hit) begin
        ptr <= is_run ? run_ptr : {1'b0, eval_w};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      op    <= item;
      fend  <= fend_n;
      addr  <= rmw_in ? {1'b0, item.position_in[11:6]} : ptr;
      end_w <= rmw_in ? fend_m1[12:6] : last_w;
      limit <= size;
      live  <= rmw_in ? ({1'b0, item.position_in} < fend_n) : (size != 13'd0);
      cnt   <= '0;
      res   <= '0;
    end
    if (ctl.init2) begin
      addr  <= '0;
      end_w <= end2;
      limit <= limit2;
      cnt   <= '0;
    end
    if (ctl.wr) begin
      addr <= addr + 7'd1;
    end
    if (ctl.grab) begin
      res.read_bit <= d[~op.position_in[5:0]];
    end
    if (ctl.zlen) begin
      res.found        <= 1'b1;
      res.position_out <= {ptr[5:0], 6'b0};
    end
    if (ctl.scan) begin
      if (issue) begin
        addr <= addr + 7'd1;
      end
      eval_w <= addr[5:0];
      if (pipe_v) begin
        if (hit) begin
          res.found        <= 1'b1;
          res.position_out <= is_run ? {run_s[5:0], 6'b0} : {eval_w, j};
        end else begin
          cnt <= full_match ? cnt_inc : 7'd0;
        end
      end
    end
  end

  assign stat.command   = op.command;
  assign stat.live      = live;
  assign stat.last_word = addr == end_w;
  assign stat.ptr_nz    = ptr != 7'd0;
  assign stat.len_zero  = op.length == 13'd0;
  assign stat.hit       = hit;
  assign stat.scan_end  = !pipe_v && !issue;
  assign result         = res;

endmodule

>>> bench/tb.sv
// self-checking bench for bitmap_allocator_top: directed and random commands
`timescale 1ns / 1ps

import bma_pkg::*;

class alloc_scoreboard;
  logic [63:0] map_w [WORD_COUNT];
  int unsigned ptr;
  int unsigned bits_cfg;
  out_item_t pending [$];
  int errors;
  int checked;

  function new();
    foreach (map_w[i]) map_w[i] = '0;
    ptr = 0;
    bits_cfg = 4096;
    errors = 0;
    checked = 0;
  endfunction

  function int unsigned size_now();
    return (bits_cfg < WORD_COUNT * WORD_BITS) ? bits_cfg : WORD_COUNT * WORD_BITS;
  endfunction

  function logic get_bit(int unsigned n);
    return map_w[(n / WORD_BITS) % WORD_COUNT][WORD_BITS - 1 - (n % WORD_BITS)];
  endfunction

  function void put_bit(int unsigned n, logic v);
    map_w[(n / WORD_BITS) % WORD_COUNT][WORD_BITS - 1 - (n % WORD_BITS)] = v;
  endfunction

  function int unsigned word_valid(int unsigned w, int unsigned sz);
    int unsigned b;
    b = w * WORD_BITS;
    if (b >= sz) return 0;
    return (sz - b < WORD_BITS) ? sz - b : WORD_BITS;
  endfunction

  function bit run_ok(int unsigned s, int unsigned len, int unsigned last,
                      int unsigned sz, logic v);
    logic [63:0] pat;
    logic [63:0] m;
    int unsigned need;
    int unsigned w;
    pat = {64{v}};
    need = len;
    w = s;
    while (need > 0) begin
      if (w > last || w >= WORD_COUNT) return 0;
      if (need >= WORD_BITS) begin
        if (word_valid(w, sz) != WORD_BITS || map_w[w] != pat) return 0;
        need -= WORD_BITS;
      end else begin
        m = ~({64{1'b1}} >> need);
        if (need > word_valid(w, sz) || (map_w[w] & m) != (pat & m)) return 0;
        need = 0;
      end
      w++;
    end
    return 1;
  endfunction

  function void note(in_item_t it);
    out_item_t r;
    int unsigned sz, last, e, s, base, hi;
    bit ok;
    r = '0;
    sz = size_now();
    case (it.command)
      CMD_READ: if (it.position_in < sz) r.read_bit = get_bit(it.position_in);
      CMD_WRITE: if (it.position_in < sz) put_bit(it.position_in, it.bit_value);
      CMD_FILL: begin
        e = it.position_in + it.length;
        if (e > sz) e = sz;
        for (int unsigned i = it.position_in; i < e; i++) put_bit(i, it.bit_value);
      end
      CMD_RUN: begin
        if (it.length == 0) begin
          r.found = 1'b1;
          r.position_out = 12'(ptr * WORD_BITS);
        end else if (sz > 0) begin
          last = (sz - 1) / WORD_BITS;
          ok = 0;
          for (s = ptr; s <= last && !ok; s++) ok = run_ok(s, it.length, last, sz, it.bit_value);
          if (!ok && ptr != 0) begin
            e = (ptr < last) ? ptr : last;
            for (s = 0; s <= e && !ok; s++) ok = run_ok(s, it.length, e, sz, it.bit_value);
          end
          if (ok) begin
            s--;
            r.found = 1'b1;
            r.position_out = 12'(s * WORD_BITS);
            ptr = s + it.length / WORD_BITS;
          end
        end
      end
      CMD_SINGLE: begin
        base = ptr * WORD_BITS;
        ok = 0;
        for (s = base; s < sz && !ok; s++) ok = (get_bit(s) == it.bit_value);
        if (!ok && ptr != 0) begin
          hi = (base < sz) ? base : sz;
          for (s = 0; s < hi && !ok; s++) ok = (get_bit(s) == it.bit_value);
        end
        if (ok) begin
          s--;
          r.found = 1'b1;
          r.position_out = 12'(s);
          ptr = s / WORD_BITS;
        end
      end
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check(out_item_t got);
    out_item_t exp_r;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %p", got);
      return;
    end
    exp_r = pending.pop_front();
    checked++;
    if (got.read_bit !== exp_r.read_bit || got.found !== exp_r.found ||
        got.position_out !== exp_r.position_out) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected rd=%0b found=%0b pos=%0d, got rd=%0b found=%0b pos=%0d",
                 exp_r.read_bit, exp_r.found, exp_r.position_out,
                 got.read_bit, got.found, got.position_out);
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t item;
  logic done;
  out_item_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [12:0] cfg_data;

  alloc_scoreboard sb;
  int idle_pct;
  int sent;

  bitmap_allocator_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
  end

  task automatic send(in_item_t it);
    @(negedge clk);
    start = 1'b1;
    item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note(it);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(8)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic set_size(logic [12:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.bits_cfg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_item_t mk(logic [2:0] c, int unsigned p, int unsigned l,
                                  int unsigned v);
    in_item_t it;
    it.command = c;
    it.position_in = 12'(p);
    it.length = 13'(l);
    it.bit_value = 1'(v);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int unsigned sz, p, l, k;
    logic [2:0] c;
    sz = sb.size_now();
    k = $urandom_range(99);
    if (k < 18) c = CMD_READ;
    else if (k < 36) c = CMD_WRITE;
    else if (k < 56) c = CMD_FILL;
    else if (k < 78) c = CMD_RUN;
    else if (k < 95) c = CMD_SINGLE;
    else c = 3'($urandom_range(5, 7));
    if (sz > 0 && $urandom_range(3) != 0) p = $urandom_range(sz - 1);
    else p = $urandom_range(4095);
    k = $urandom_range(9);
    if (k < 2) l = $urandom_range(3);
    else if (k < 5) l = $urandom_range(1, 200);
    else if (k < 8) l = 64 * $urandom_range(1, 4);
    else if (k < 9) l = $urandom_range(4096);
    else l = (c == CMD_FILL && $urandom_range(1)) ? 8191 - $urandom_range(7) : 4096;
    if (c == CMD_FILL && $urandom_range(2) == 0) p = p & ~32'h3f;
    return mk(c, p, l, $urandom_range(1));
  endfunction

  initial begin
    logic [12:0] sizes [6];
    int modes [4];
    sizes = '{13'd4096, 13'd700, 13'd0, 13'd1, 13'd8191, 13'd130};
    modes = '{0, 70, 0, 17};
    sb = new();
    sent = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(mk(CMD_READ, 0, 0, 0));
    send(mk(CMD_READ, 4095, 0, 0));
    send(mk(CMD_SINGLE, 0, 0, 1));
    send(mk(CMD_RUN, 0, 0, 1));
    send(mk(CMD_RUN, 0, 64, 0));
    send(mk(CMD_WRITE, 0, 0, 1));
    send(mk(CMD_WRITE, 4095, 0, 1));
    send(mk(CMD_READ, 4095, 0, 0));
    send(mk(CMD_SINGLE, 0, 0, 1));
    send(mk(CMD_FILL, 4095, 8191, 1));
    send(mk(CMD_FILL, 0, 4096, 1));
    send(mk(CMD_RUN, 0, 4096, 1));
    send(mk(CMD_SINGLE, 0, 0, 0));
    send(mk(CMD_RUN, 0, 0, 1));
    send(mk(CMD_FILL, 128, 100, 0));
    send(mk(CMD_RUN, 0, 100, 0));
    send(mk(CMD_RUN, 0, 4096, 0));
    send(mk(CMD_SINGLE, 0, 0, 0));
    send(mk(CMD_FILL, 100, 0, 0));
    send(mk(3'd5, 4095, 8191, 1));
    send(mk(3'd7, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = modes[ph % 4];
      set_size(sizes[ph % 6]);
      for (int i = 0; i < 175; i++) send(rand_item());
      drain();
    end
    set_size(13'd4096);
    for (int i = 0; i < 40; i++) send(rand_item());
    drain();

    $display("ran %0d commands, %0d results checked, over six map sizes and idle mixes",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end
endmodule
